>>> rtl/etrs_pkg.sv
// etrs_pkg: constants, item and result types for the edge table relation search
// no dependencies; used by etrs_scan and edge_table_relation_search by scoped names
`timescale 1ns / 1ps
`default_nettype none
package etrs_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int NODE_WIDTH  = 16;
	localparam int ENTRY_W     = 5;
	localparam int REL_W       = 2;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam logic [NODE_WIDTH-1:0] ROOT_NODE = NODE_WIDTH'(1);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic                  op;
		logic [ENTRY_W-1:0]    entry_index;
		logic [NODE_WIDTH-1:0] edge_source;
		logic [NODE_WIDTH-1:0] edge_target;
		logic [REL_W-1:0]      edge_relation;
		logic [NODE_WIDTH-1:0] query_node;
		logic [REL_W-1:0]      query_relation;
		logic                  parent_search;
	} item_t;

	typedef struct packed {
		logic [NODE_WIDTH-1:0] found_node;
		logic                  has_match;
		logic                  last;
	} result_t;

	typedef struct packed {
		logic [NODE_WIDTH-1:0] src;
		logic [NODE_WIDTH-1:0] dst;
		logic [REL_W-1:0]      rel;
	} edge_t;

	typedef struct packed {
		logic             re;
		logic [IDX_W-1:0] addr;
	} rd_req_t;

endpackage
`default_nettype wire

>>> rtl/etrs_ram.sv
// etrs_ram: generic single write port, single read port ram with registered read data
// no dependencies; read data holds while re is low
`timescale 1ns / 1ps
`default_nettype none
module etrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/etrs_scan.sv
// etrs_scan: query sequencer; walks the edge ram one entry a cycle unless stalled, matches,
// drives results; depends on etrs_pkg; last match is held until the walk ends to be flagged
`timescale 1ns / 1ps
`default_nettype none
module etrs_scan (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire etrs_pkg::item_t               query,
	input  wire logic [etrs_pkg::TABLE_DEPTH-1:0] entry_valid,
	output etrs_pkg::rd_req_t                  rd_req,
	input  wire etrs_pkg::edge_t               rd_data,
	output logic                               busy,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output etrs_pkg::result_t                  result
);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FLUSH} state_t;

	state_t                              state_q;
	logic [etrs_pkg::CNT_W-1:0]          cnt_q;
	logic                                v_s1;
	logic                                ent_v_s1;
	logic [etrs_pkg::NODE_WIDTH-1:0]     q_node_q;
	logic [etrs_pkg::REL_W-1:0]          q_rel_q;
	logic                                q_par_q;
	logic                                q_root_q;
	logic                                pend_v_q;
	logic [etrs_pkg::NODE_WIDTH-1:0]     pend_node_q;
	logic                                out_v_q;
	etrs_pkg::result_t                   out_q;

	logic [etrs_pkg::NODE_WIDTH-1:0] key;
	logic [etrs_pkg::NODE_WIDTH-1:0] other;
	logic                            hit;
	logic                            out_busy;
	logic                            adv;
	logic                            issue;
	logic                            walked;
	logic                            out_set;

	always_comb begin
		key      = q_par_q ? rd_data.dst : rd_data.src;
		other    = q_par_q ? rd_data.src : rd_data.dst;
		hit      = v_s1 && ent_v_s1 && !q_root_q && (rd_data.rel == q_rel_q) && (key == q_node_q);
		out_busy = out_v_q && result_stall;
		adv      = !(hit && pend_v_q && out_busy);
		walked   = (cnt_q == etrs_pkg::CNT_W'(etrs_pkg::TABLE_DEPTH));
		issue    = (state_q == S_SCAN) && !walked && adv;
		out_set  = ((state_q == S_SCAN) && adv && hit && pend_v_q)
		           || ((state_q == S_FLUSH) && !out_busy);
		rd_req.re   = issue;
		rd_req.addr = cnt_q[etrs_pkg::IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			ent_v_s1    <= 1'b0;
			q_node_q    <= '0;
			q_rel_q     <= '0;
			q_par_q     <= 1'b0;
			q_root_q    <= 1'b0;
			pend_v_q    <= 1'b0;
			pend_node_q <= '0;
			out_v_q     <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_set) begin
				out_v_q <= 1'b1;
			end else if (!result_stall) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						q_node_q <= query.query_node;
						q_rel_q  <= query.query_relation;
						q_par_q  <= query.parent_search;
						q_root_q <= query.parent_search && (query.query_node == etrs_pkg::ROOT_NODE);
						cnt_q    <= '0;
						v_s1     <= 1'b0;
						pend_v_q <= 1'b0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (adv) begin
						v_s1 <= issue;
						if (issue) begin
							cnt_q    <= cnt_q + etrs_pkg::CNT_W'(1);
							ent_v_s1 <= entry_valid[rd_req.addr];
						end
						if (hit) begin
							pend_node_q <= other;
							pend_v_q    <= 1'b1;
							if (pend_v_q) begin
								out_q <= '{found_node: pend_node_q, has_match: 1'b1,
								           last: 1'b0};
							end
						end
					end
					if (walked && !v_s1) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (!out_busy) begin
						out_q    <= '{found_node: pend_v_q ? pend_node_q : '0,
						              has_match: pend_v_q, last: 1'b1};
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = out_v_q;
	assign result       = out_q;

endmodule
`default_nettype wire

>>> rtl/edge_table_relation_search.sv
// edge_table_relation_search: top level; load decode, entry valid flags, edge ram, scan
// depends on etrs_pkg, etrs_ram, etrs_scan
//
// channel  | signals                           | payload
// item     | item_valid, item_stall, item      | etrs_pkg::item_t (load or query)
// result   | result_valid, result_stall, result| etrs_pkg::result_t
//
// a load writes the ram and sets its entry valid flag when taken, and gives no result
// a query walks every entry through the single ram read port, one entry a cycle unless stalled
// item_stall stays high from the query transfer until its last result is in the output register
// result stalls pause the walk only when a second match is waiting behind a held result
// reset clears the entry valid flags at once; the ram itself is never cleared
`timescale 1ns / 1ps
`default_nettype none
module edge_table_relation_search (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire etrs_pkg::item_t    item,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output etrs_pkg::result_t       result
);

	logic [etrs_pkg::TABLE_DEPTH-1:0] valid_q;
	logic                             busy;
	logic                             take;
	logic                             load_we;
	logic [etrs_pkg::IDX_W-1:0]       waddr;
	etrs_pkg::edge_t                  wdata;
	etrs_pkg::edge_t                  rd_data;
	etrs_pkg::rd_req_t                rd_req;

	assign item_stall = busy;
	assign take       = item_valid && !item_stall;
	assign load_we    = take && (item.op == etrs_pkg::OP_LOAD)
	                    && (32'(item.entry_index) < etrs_pkg::TABLE_DEPTH);
	assign waddr      = etrs_pkg::IDX_W'(item.entry_index);
	assign wdata      = '{src: item.edge_source, dst: item.edge_target,
	                      rel: item.edge_relation};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (load_we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	etrs_ram #(
		.WIDTH($bits(etrs_pkg::edge_t)),
		.DEPTH(etrs_pkg::TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (load_we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (rd_req.re),
		.raddr(rd_req.addr),
		.rdata(rd_data)
	);

	etrs_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (take && (item.op == etrs_pkg::OP_QUERY)),
		.query       (item),
		.entry_valid (valid_q),
		.rd_req      (rd_req),
		.rd_data     (rd_data),
		.busy        (busy),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.has_match |-> result.last)
		else $error("empty result without last flag");

	a_empty_node_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.has_match |-> (result.found_node == '0))
		else $error("empty result carries a node");

	a_query_holds_off: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (item.op == etrs_pkg::OP_QUERY) |=> item_stall)
		else $error("query transfer did not hold off the next item");

endmodule
`default_nettype wire
